// ----- hw/rtl/rc4ks_pkg.sv -----
// ----------------------------------------------------------------------------
// RC4 keystream package
// Shared widths, command codes, sequencer states and the memory write bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4ks_pkg;

    localparam int FUNC_W     = 2;
    localparam int KEY_IDX_W  = 4;
    localparam int BYTE_W     = 8;
    localparam int KEY_LEN_W  = 5;
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = 8;

    // command codes carried in the func field
    localparam logic [FUNC_W-1:0] FUNC_KEY_WR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SCHED  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_KS     = 2'd2;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 5'd5;

    // sequencer states, one-hot
    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_S_RA   = 10'b00_0000_0010,
        ST_S_RB   = 10'b00_0000_0100,
        ST_S_WA   = 10'b00_0000_1000,
        ST_S_WB   = 10'b00_0001_0000,
        ST_K_RI   = 10'b00_0010_0000,
        ST_K_RJ   = 10'b00_0100_0000,
        ST_K_WI   = 10'b00_1000_0000,
        ST_K_WJ   = 10'b01_0000_0000,
        ST_K_OUT  = 10'b10_0000_0000
    } t_state;

    // write request to the permutation memory
    typedef struct packed {
        logic               en;
        logic [PERM_AW-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } t_perm_wr;

endpackage

`default_nettype wire

// ----- hw/rtl/rc4ks_ifs.sv -----
// ----------------------------------------------------------------------------
// RC4 keystream channel interfaces
// Command channel (func, key index, key byte) and keystream byte channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4ks_in_if import rc4ks_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [KEY_IDX_W-1:0] key_index;
    logic [BYTE_W-1:0]    key_byte;

    modport source (output valid, output func, output key_index, output key_byte,
                    input ready);
    modport sink   (input valid, input func, input key_index, input key_byte,
                    output ready);
endinterface

interface rc4ks_out_if import rc4ks_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] keystream_byte;

    modport source (output valid, output keystream_byte, input ready);
    modport sink   (input valid, input keystream_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rc4_keystream_generator_core.sv -----
// ----------------------------------------------------------------------------
// RC4 keystream generator core
// Key store, key schedule and keystream generation around one permutation
// memory and one shared 8-bit three-input adder under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one command word: func 0 writes key_byte at key_index
//   (indexes at or beyond MAX_KEY_BYTES are dropped), func 1 runs the key
//   schedule over key_length key bytes and clears i and j, func 2 returns
//   one keystream byte on o_out, func 3 does nothing. Only func 2 gives a
//   word on o_out.
//   key_length is written through i_cfg_we / i_cfg_wdata while idle; zero
//   counts as one and values above MAX_KEY_BYTES saturate.
// Timing:
//   i_in.ready is high only while the sequencer is idle. Key writes and
//   func 3 leave the sequencer idle. A keystream byte reaches the output
//   register after two reads, two swap writes and a final read of the
//   permutation memory; no new command is taken meanwhile. The key
//   schedule does two reads and two swap writes per entry over all 256.
// Reset and stalls:
//   Synchronous reset returns the permutation to identity, i = j = 0,
//   key_length = 5 and empties the output register; key store contents are
//   undefined until written. While o_out is stalled the next command is
//   still accepted; a second keystream byte waits in its last step until
//   the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_keystream_generator_core import rc4ks_pkg::*; #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [KEY_LEN_W-1:0] i_cfg_wdata,
    rc4ks_in_if.sink                  i_in,
    rc4ks_out_if.source               o_out
);

    localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int CW = 10;  // compare width, holds 0..256

    t_state                r_state, n_state;
    logic [KEY_LEN_W-1:0]  r_key_len;
    logic [BYTE_W-1:0]     r_key [MAX_KEY_BYTES];
    logic [KW-1:0]         r_kp, n_kp;
    logic [PERM_AW-1:0]    r_i, n_i, r_j, n_j, r_a, n_a, r_b, n_b, r_t, n_t;
    logic [BYTE_W-1:0]     r_sa, n_sa, r_sb, n_sb;
    logic                  r_fwd, n_fwd;
    logic                  r_out_vld, n_out_vld;
    logic [BYTE_W-1:0]     r_out_byte, n_out_byte;

    logic                  w_accept;
    logic                  w_clr;
    t_perm_wr              w_wr;
    logic [PERM_AW-1:0]    w_rd_addr;
    logic [BYTE_W-1:0]     w_rd_data;
    logic [BYTE_W-1:0]     w_op_a, w_op_b, w_op_c;
    logic [BYTE_W+1:0]     w_sum_full;
    logic [BYTE_W-1:0]     w_sum;
    logic [CW-1:0]         w_len_used;
    logic [CW-1:0]         w_kp_ext;
    logic [CW-1:0]         w_kidx_ext;
    logic [BYTE_W-1:0]     w_key_rd;

    assign w_accept  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // effective key length: zero counts as one, saturate at the store depth
    always_comb begin
        w_len_used = CW'(r_key_len);
        if (r_key_len == '0) begin
            w_len_used = CW'(1);
        end else if (CW'(r_key_len) > CW'(MAX_KEY_BYTES)) begin
            w_len_used = CW'(MAX_KEY_BYTES);
        end
    end

    assign w_kp_ext   = CW'(r_kp);
    assign w_kidx_ext = CW'(i_in.key_index);
    assign w_key_rd   = r_key[r_kp];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= KEY_LEN_RST;
        end else if (i_cfg_we) begin
            r_key_len <= i_cfg_wdata;
        end
    end

    // key store, written by func 0 words
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in.func == FUNC_KEY_WR)
            && (w_kidx_ext < CW'(MAX_KEY_BYTES))) begin
            r_key[w_kidx_ext[KW-1:0]] <= i_in.key_byte;
        end
    end

    // shared adder: operands chosen by the sequencer state
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        w_op_c = '0;
        case (r_state)
            ST_K_RI: begin
                w_op_a = r_i;
                w_op_b = BYTE_W'(1);
            end
            ST_K_RJ: begin
                w_op_a = r_j;
                w_op_b = w_rd_data;
            end
            ST_K_WJ: begin
                w_op_a = r_sa;
                w_op_b = r_sb;
            end
            ST_S_RB: begin
                w_op_a = r_b;
                w_op_b = w_rd_data;
                w_op_c = w_key_rd;
            end
            default: begin
                w_op_a = '0;
            end
        endcase
    end

    assign w_sum_full = (BYTE_W+2)'(w_op_a) + (BYTE_W+2)'(w_op_b) + (BYTE_W+2)'(w_op_c);
    assign w_sum      = w_sum_full[BYTE_W-1:0];

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_kp       = r_kp;
        n_i        = r_i;
        n_j        = r_j;
        n_a        = r_a;
        n_b        = r_b;
        n_t        = r_t;
        n_sa       = r_sa;
        n_sb       = r_sb;
        n_fwd      = r_fwd;
        n_out_vld  = r_out_vld && !o_out.ready;
        n_out_byte = r_out_byte;
        w_clr      = 1'b0;
        w_wr       = '0;
        w_rd_addr  = r_a;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_in.func == FUNC_SCHED)) begin
                    w_clr   = 1'b1;
                    n_a     = '0;
                    n_b     = '0;
                    n_kp    = '0;
                    n_state = ST_S_RA;
                end else if (w_accept && (i_in.func == FUNC_KS)) begin
                    n_state = ST_K_RI;
                end
            end
            // key schedule: read S[a]
            ST_S_RA: begin
                w_rd_addr = r_a;
                n_state   = ST_S_RB;
            end
            // advance b and read S[b]
            ST_S_RB: begin
                n_sa      = w_rd_data;
                n_b       = w_sum;
                w_rd_addr = w_sum;
                n_state   = ST_S_WA;
            end
            // swap, first half: S[a] <= S[b]
            ST_S_WA: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_a;
                w_wr.data = w_rd_data;
                n_state   = ST_S_WB;
            end
            // swap, second half: S[b] <= old S[a]; advance a and key pointer
            ST_S_WB: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_b;
                w_wr.data = r_sa;
                n_a       = r_a + PERM_AW'(1);
                if (w_kp_ext == w_len_used - CW'(1)) begin
                    n_kp = '0;
                end else begin
                    n_kp = r_kp + KW'(1);
                end
                if (r_a == PERM_AW'(PERM_DEPTH - 1)) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_S_RA;
                end
            end
            // keystream: step i and read S[i]
            ST_K_RI: begin
                n_i       = w_sum;
                w_rd_addr = w_sum;
                n_state   = ST_K_RJ;
            end
            // add S[i] to j and read S[j]
            ST_K_RJ: begin
                n_sa      = w_rd_data;
                n_j       = w_sum;
                w_rd_addr = w_sum;
                n_state   = ST_K_WI;
            end
            // swap, first half: S[i] <= S[j]
            ST_K_WI: begin
                n_sb      = w_rd_data;
                w_wr.en   = 1'b1;
                w_wr.addr = r_i;
                w_wr.data = w_rd_data;
                n_state   = ST_K_WJ;
            end
            // swap, second half, and read S[S[i]+S[j]]; forward if it hits j
            ST_K_WJ: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_j;
                w_wr.data = r_sa;
                n_t       = w_sum;
                w_rd_addr = w_sum;
                n_fwd     = (w_sum == r_j);
                n_state   = ST_K_OUT;
            end
            // hold the read until the output register frees
            ST_K_OUT: begin
                w_rd_addr = r_t;
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld  = 1'b1;
                    n_out_byte = r_fwd ? r_sa : w_rd_data;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_i       <= n_i;
            r_j       <= n_j;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_kp       <= n_kp;
        r_a        <= n_a;
        r_b        <= n_b;
        r_t        <= n_t;
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_fwd      <= n_fwd;
        r_out_byte <= n_out_byte;
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.keystream_byte = r_out_byte;

    rc4ks_perm_mem u_perm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_clr),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/rc4ks_perm_mem.sv -----
// ----------------------------------------------------------------------------
// RC4 permutation memory
// 256 x 8 single-port-write, single-read memory with registered read data.
// Per-entry valid bits give identity contents after reset or a clear.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4ks_perm_mem import rc4ks_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_clr,
    input  wire t_perm_wr           i_wr,
    input  wire logic [PERM_AW-1:0] i_rd_addr,
    output logic      [BYTE_W-1:0]  o_rd_data
);

    logic [BYTE_W-1:0]     r_mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] r_vld;
    logic [BYTE_W-1:0]     r_rd_data;
    logic                  r_rd_hit;
    logic [PERM_AW-1:0]    r_rd_addr;

    // write port and read register
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    // valid bits: drop all on reset or clear, mark each written entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_rd_hit <= r_vld[i_rd_addr];
        end
    end

    // an entry never written since the last clear holds its own index
    assign o_rd_data = r_rd_hit ? r_rd_data : BYTE_W'(r_rd_addr);

endmodule

`default_nettype wire

// ----- hw/rtl/rc4ks_chk.sv -----
// ----------------------------------------------------------------------------
// RC4 keystream port checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4ks_chk import rc4ks_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic [FUNC_W-1:0] i_in_func,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [BYTE_W-1:0] i_out_byte
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // leave reset idle with an empty output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("core not idle after reset");

    // hold a stalled keystream word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("stalled keystream word changed or dropped");

    // schedule and keystream commands leave the core busy in the cycle after accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_func == FUNC_SCHED || i_in_func == FUNC_KS)
        |=> !i_in_ready)
        else $error("core ready right after a multi-cycle command");

    // commands other than keystream never raise the output
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_func != FUNC_KS && !i_out_valid |=> !i_out_valid)
        else $error("keystream word without a keystream command");

endmodule

bind rc4_keystream_generator_core rc4ks_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_func   (i_in.func),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.keystream_byte)
);

`default_nettype wire

// ----- dv/rc4ks_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC4 keystream checker
// Watches the command and keystream channels and the key length port, keeps
// its own copy of the permutation, indices, key store and key length, and
// compares every keystream word that leaves the core with the oldest
// predicted byte. Reports mismatches and hands the failure count and the
// number of outstanding bytes to the testbench top.
// ----------------------------------------------------------------------------

module rc4ks_checker import rc4ks_pkg::*; #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [KEY_LEN_W-1:0] i_cfg_wdata,
    rc4ks_in_if                  i_cmd,
    rc4ks_out_if                 i_ks,
    output int                   o_fail_count,
    output int                   o_words_pending
);

    // shadow state of the core
    logic [BYTE_W-1:0]    perm [PERM_DEPTH];
    logic [BYTE_W-1:0]    key_store [MAX_KEY_BYTES];
    logic [BYTE_W-1:0]    idx_i;
    logic [BYTE_W-1:0]    idx_j;
    logic [KEY_LEN_W-1:0] key_len;

    logic [BYTE_W-1:0]    keystream_due [$];
    logic [BYTE_W-1:0]    due_byte;
    int                   fail_count = 0;

    initial begin
        o_fail_count    = 0;
        o_words_pending = 0;
    end

    function automatic void load_identity();
        for (int k = 0; k < PERM_DEPTH; k++) perm[k] = k[BYTE_W-1:0];
    endfunction

    // key schedule over the effective key length, then clear both indices
    function automatic void rebuild_permutation();
        int unsigned       n;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] t;
        n = key_len;
        if (n == 0) n = 1;
        if (n > MAX_KEY_BYTES) n = MAX_KEY_BYTES;
        load_identity();
        b = '0;
        for (int a = 0; a < PERM_DEPTH; a++) begin
            b = b + perm[a] + key_store[a % n];
            t = perm[a];
            perm[a] = perm[b];
            perm[b] = t;
        end
        idx_i = '0;
        idx_j = '0;
    endfunction

    // one keystream step: advance i, add S[i] to j, swap, look up the sum
    function automatic logic [BYTE_W-1:0] next_keystream_byte();
        logic [BYTE_W-1:0] t;
        logic [BYTE_W-1:0] sum;
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + perm[idx_i];
        t = perm[idx_i];
        perm[idx_i] = perm[idx_j];
        perm[idx_j] = t;
        sum = perm[idx_i] + perm[idx_j];
        return perm[sum];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_identity();
            idx_i   = '0;
            idx_j   = '0;
            key_len = KEY_LEN_RST;
            for (int k = 0; k < MAX_KEY_BYTES; k++) key_store[k] = '0;
            keystream_due.delete();
        end else begin
            // compare the outgoing word before taking a new command
            if (i_ks.valid && i_ks.ready) begin
                if (keystream_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected keystream word, actual %02h",
                             $time, i_ks.keystream_byte);
                end else begin
                    due_byte = keystream_due.pop_front();
                    if (i_ks.keystream_byte !== due_byte) begin
                        fail_count++;
                        $display("%0t: keystream_byte mismatch, expected %02h actual %02h",
                                 $time, due_byte, i_ks.keystream_byte);
                    end
                end
            end

            if (i_cfg_we) key_len = i_cfg_wdata;

            // apply an accepted command word to the shadow state
            if (i_cmd.valid && i_cmd.ready) begin
                case (i_cmd.func)
                    FUNC_KEY_WR: begin
                        if (i_cmd.key_index < MAX_KEY_BYTES)
                            key_store[i_cmd.key_index] = i_cmd.key_byte;
                    end
                    FUNC_SCHED: rebuild_permutation();
                    FUNC_KS:    keystream_due.push_back(next_keystream_byte());
                    default: ;
                endcase
            end
        end
        o_fail_count    <= fail_count;
        o_words_pending <= keystream_due.size();
    end

endmodule

// ----- dv/tb_rc4_keystream_generator_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC4 keystream generator core testbench
// Drives key writes, key schedules, keystream requests and unused commands
// with random gaps on both channels, steps the key length through its
// extremes between phases, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------

module tb_rc4_keystream_generator_core;
    import rc4ks_pkg::*;

    localparam int                MAX_KEY_BYTES = 16;
    localparam logic [FUNC_W-1:0] FUNC_NOP      = 2'd3;
    // the settle wait covers a whole key schedule, which gives no word
    localparam int                SETTLE_CYCLES = 1100;
    localparam int                CYCLE_LIMIT   = 1000000;
    localparam int                PHASE_ITEMS   = 82;
    localparam int                HOLD_AFTER    = 40;
    localparam int                HOLD_CYCLES   = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [KEY_LEN_W-1:0] i_cfg_wdata;

    int fail_count;
    int words_pending;
    int ks_words_taken = 0;
    int cycle_count    = 0;

    rc4ks_in_if  cmd_if ();
    rc4ks_out_if ks_if ();

    rc4_keystream_generator_core #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (cmd_if),
        .o_out      (ks_if)
    );

    rc4ks_checker #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_ks_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd_if),
        .i_ks           (ks_if),
        .o_fail_count   (fail_count),
        .o_words_pending(words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // give up on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (ks_if.valid && ks_if.ready) ks_words_taken++;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // keystream receiver: random stalls, one long hold to back the core up
    initial begin : ks_sink
        int gap;
        int run;
        bit hold_done;
        hold_done = 1'b0;
        ks_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            ks_if.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 12);
            repeat (run) @(posedge i_clk);
            if (!hold_done && ks_words_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                gap = HOLD_CYCLES;
            end else begin
                gap = idle_cycles();
            end
            if (gap > 0) begin
                ks_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // offer one command word, hold until taken, then idle a while unless quiet
    task automatic send_word(input logic [FUNC_W-1:0] func,
                             input logic [KEY_IDX_W-1:0] key_index,
                             input logic [BYTE_W-1:0] key_byte,
                             input bit quiet);
        int gap;
        cmd_if.valid     <= 1'b1;
        cmd_if.func      <= func;
        cmd_if.key_index <= key_index;
        cmd_if.key_byte  <= key_byte;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        gap = quiet ? 0 : idle_cycles();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input logic [FUNC_W-1:0] func, input bit quiet);
        send_word(func, KEY_IDX_W'($urandom), BYTE_W'($urandom), quiet);
    endtask

    // wait for every byte and for a schedule still in flight
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (words_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_key_length(input logic [KEY_LEN_W-1:0] len);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // key refresh, usually a schedule, then a keystream run with some noise mixed in
    task automatic run_sessions(input int budget);
        int sent;
        int r;
        bit quiet;
        sent = 0;
        while (sent < budget) begin
            quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 4)) begin
                send_random(FUNC_KEY_WR, quiet);
                sent++;
            end
            if ($urandom_range(0, 5) != 0) begin
                send_random(FUNC_SCHED, quiet);
                sent++;
            end
            repeat ($urandom_range(4, 24)) begin
                r = $urandom_range(0, 19);
                if (r == 0)      send_random(FUNC_NOP, quiet);
                else if (r == 1) send_random(FUNC_KEY_WR, quiet);
                else if (r == 2) send_random(FUNC_SCHED, quiet);
                else             send_random(FUNC_KS, quiet);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        logic [BYTE_W-1:0]    seed_key [MAX_KEY_BYTES];
        logic [KEY_LEN_W-1:0] phase_len [6];

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        cmd_if.valid     <= 1'b0;
        cmd_if.func      <= FUNC_KEY_WR;
        cmd_if.key_index <= '0;
        cmd_if.key_byte  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // keystream straight from the identity permutation, unused code
        send_word(FUNC_KS, 4'h0, 8'h00, 1'b0);
        send_word(FUNC_KS, 4'h0, 8'h00, 1'b0);
        send_word(FUNC_NOP, 4'hf, 8'hff, 1'b0);

        // fill the whole key store so no schedule reads an unwritten byte
        seed_key = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'haa, 8'h55, 8'hfe,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff};
        for (int k = 8; k < MAX_KEY_BYTES - 1; k++) seed_key[k] = BYTE_W'($urandom);
        for (int k = 0; k < MAX_KEY_BYTES; k++)
            send_word(FUNC_KEY_WR, k[KEY_IDX_W-1:0], seed_key[k], 1'b0);

        send_word(FUNC_SCHED, 4'h0, 8'h00, 1'b0);
        repeat (3) send_word(FUNC_KS, 4'hf, 8'hff, 1'b1);
        send_word(FUNC_KEY_WR, 4'h3, 8'hff, 1'b0);
        send_word(FUNC_NOP, 4'h0, 8'h00, 1'b0);
        send_word(FUNC_KS, 4'h5, 8'h5a, 1'b0);

        // first random phase at the reset key length
        run_sessions(PHASE_ITEMS - 24);
        drain();

        // step the key length through zero, the top, saturation and one
        phase_len = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd17, 5'd0};
        phase_len[5] = KEY_LEN_W'($urandom_range(2, 15));
        foreach (phase_len[p]) begin
            write_key_length(phase_len[p]);
            send_random(FUNC_SCHED, 1'b0);
            run_sessions(PHASE_ITEMS);
            drain();
        end

        if (fail_count == 0 && words_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
